FILE: sv/dpp_pkg.sv
package dpp_pkg;

	// field widths
	localparam int CODE_BITS  = 12;
	localparam int TRAVEL_W   = 16;
	localparam int COUNT_W    = 16;
	localparam int IN_DATA_W  = ((2 * CODE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((3 * TRAVEL_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 3;

	// serial divider: one quotient bit per step
	localparam int DIV_STEPS = TRAVEL_W;
	localparam int ITER_W    = $clog2(DIV_STEPS);
	localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(DIV_STEPS - 1);

	// apb register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_FIRST_LOW   = 3'd0;
	localparam logic [2:0] REG_FIRST_HIGH  = 3'd1;
	localparam logic [2:0] REG_SECOND_LOW  = 3'd2;
	localparam logic [2:0] REG_SECOND_HIGH = 3'd3;
	localparam logic [2:0] REG_GAP_LIMIT   = 3'd4;
	localparam logic [2:0] REG_PERSIST     = 3'd5;
	localparam logic [2:0] REG_OVER_RANGE  = 3'd6;

	// register reset values
	localparam logic [CODE_BITS-1:0] RST_LOW        = CODE_BITS'(410);
	localparam logic [CODE_BITS-1:0] RST_HIGH       = CODE_BITS'(3277);
	localparam logic [TRAVEL_W-1:0]  RST_GAP_LIMIT  = TRAVEL_W'(6554);
	localparam logic [COUNT_W-1:0]   RST_PERSIST    = COUNT_W'(100);
	localparam logic [CODE_BITS-1:0] RST_OVER_RANGE = CODE_BITS'(3686);

	// micro-operations
	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_SETUP = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_STORE = 3'd4;
	localparam logic [2:0] OP_CHECK = 3'd5;
	localparam logic [2:0] OP_EMIT  = 3'd6;

	// hold conditions: the step repeats while its condition is true
	localparam logic [1:0] W_NONE     = 2'd0;
	localparam logic [1:0] W_NO_IN    = 2'd1;
	localparam logic [1:0] W_DIV      = 2'd2;
	localparam logic [1:0] W_OUT_FULL = 2'd3;

	localparam int STEP_W = 4;

	typedef struct packed {
		logic [2:0] op;
		logic       sel;
		logic [1:0] waitc;
		logic       last;
	} ucode_t;

	typedef struct packed {
		logic [2:0] op;
		logic       sel;
		logic       go;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic div_more;
		logic out_full;
	} status_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] first_low;
		logic [CODE_BITS-1:0] first_high;
		logic [CODE_BITS-1:0] second_low;
		logic [CODE_BITS-1:0] second_high;
		logic [TRAVEL_W-1:0]  gap_limit;
		logic [COUNT_W-1:0]   persist;
		logic [CODE_BITS-1:0] over_range;
	} cfg_t;

	// control store
	function automatic ucode_t dpp_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		unique case (step)
			4'd0: uc = '{op: OP_LOAD,  sel: 1'b0, waitc: W_NO_IN,    last: 1'b0};
			4'd1: uc = '{op: OP_SETUP, sel: 1'b0, waitc: W_NONE,     last: 1'b0};
			4'd2: uc = '{op: OP_DIV,   sel: 1'b0, waitc: W_DIV,      last: 1'b0};
			4'd3: uc = '{op: OP_STORE, sel: 1'b0, waitc: W_NONE,     last: 1'b0};
			4'd4: uc = '{op: OP_SETUP, sel: 1'b1, waitc: W_NONE,     last: 1'b0};
			4'd5: uc = '{op: OP_DIV,   sel: 1'b1, waitc: W_DIV,      last: 1'b0};
			4'd6: uc = '{op: OP_STORE, sel: 1'b1, waitc: W_NONE,     last: 1'b0};
			4'd7: uc = '{op: OP_CHECK, sel: 1'b0, waitc: W_NONE,     last: 1'b0};
			4'd8: uc = '{op: OP_EMIT,  sel: 1'b0, waitc: W_OUT_FULL, last: 1'b1};
			default: uc = '{op: OP_NOP, sel: 1'b0, waitc: W_NONE, last: 1'b1};
		endcase
		return uc;
	endfunction

endpackage

FILE: sv/dual_pedal_plausibility_check.sv
// channel | dir | tdata (low bit up)                          | tuser (low bit up)
// s_axis  | in  | first_code[11:0], second_code[23:12]         | -
// m_axis  | out | avg_travel, first_travel, second_travel      | mismatch, range, motor_cut
// apb     | in  | 7 registers at byte addresses 0..24          | -
//
// an item takes one accept step, then two 16-step serial divides
// (one quotient bit per cycle) plus six further microcode steps
// the next item is taken while the finished word waits in the output register
// the last step stalls only while that register is still full
// reset restores the default calibration and clears the gap counter
module dual_pedal_plausibility_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [dpp_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // first_code, second_code
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [dpp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // pedal, first, second travel
	output logic [dpp_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // mismatch, range, motor_cut
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dpp_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import dpp_pkg::*;

	cfg_t    cfg_q;
	ctl_t    ctl;
	status_t st;
	logic    wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_low   <= RST_LOW;
			cfg_q.first_high  <= RST_HIGH;
			cfg_q.second_low  <= RST_LOW;
			cfg_q.second_high <= RST_HIGH;
			cfg_q.gap_limit   <= RST_GAP_LIMIT;
			cfg_q.persist     <= RST_PERSIST;
			cfg_q.over_range  <= RST_OVER_RANGE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIRST_LOW:   cfg_q.first_low   <= pwdata[CODE_BITS-1:0];
				REG_FIRST_HIGH:  cfg_q.first_high  <= pwdata[CODE_BITS-1:0];
				REG_SECOND_LOW:  cfg_q.second_low  <= pwdata[CODE_BITS-1:0];
				REG_SECOND_HIGH: cfg_q.second_high <= pwdata[CODE_BITS-1:0];
				REG_GAP_LIMIT:   cfg_q.gap_limit   <= pwdata[TRAVEL_W-1:0];
				REG_PERSIST:     cfg_q.persist     <= pwdata[COUNT_W-1:0];
				REG_OVER_RANGE:  cfg_q.over_range  <= pwdata[CODE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				REG_FIRST_LOW:   prdata = 32'(cfg_q.first_low);
				REG_FIRST_HIGH:  prdata = 32'(cfg_q.first_high);
				REG_SECOND_LOW:  prdata = 32'(cfg_q.second_low);
				REG_SECOND_HIGH: prdata = 32'(cfg_q.second_high);
				REG_GAP_LIMIT:   prdata = 32'(cfg_q.gap_limit);
				REG_PERSIST:     prdata = 32'(cfg_q.persist);
				REG_OVER_RANGE:  prdata = 32'(cfg_q.over_range);
				default:         prdata = '0;
			endcase
		end
	end

	assign s_axis_tready = (ctl.op == OP_LOAD);

	dpp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	dpp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg_q),
		.in_first  (s_axis_tdata[CODE_BITS-1:0]),
		.in_second (s_axis_tdata[2*CODE_BITS-1:CODE_BITS]),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

`ifndef NO_ASSERTIONS
	// an accepted word goes straight into the first setup step
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (ctl.op == OP_SETUP && !ctl.sel))
		else $error("accept not followed by setup");
	// the divide loop ends in a store
	a_div_store: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_DIV && !st.div_more) |=> (ctl.op == OP_STORE))
		else $error("divide loop did not end in store");
	// motor cut follows the two fault flags
	a_motor_cut: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[0] | m_axis_tuser[1])))
		else $error("motor cut inconsistent with faults");
`endif

endmodule

FILE: sv/dpp_seq.sv
module dpp_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  dpp_pkg::status_t st,
	output dpp_pkg::ctl_t    ctl
);
	import dpp_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	ucode_t            uc;
	logic              hold;

	// fetch and condition decode
	always_comb begin
		uc = dpp_rom(step_q);
		unique case (uc.waitc)
			W_NONE:     hold = 1'b0;
			W_NO_IN:    hold = !st.in_valid;
			W_DIV:      hold = st.div_more;
			W_OUT_FULL: hold = st.out_full;
			default:    hold = 1'b0;
		endcase
		if (hold) begin
			step_next = step_q;
		end else if (uc.last) begin
			step_next = '0;
		end else begin
			step_next = step_q + STEP_W'(1);
		end
		ctl.op  = uc.op;
		ctl.sel = uc.sel;
		ctl.go  = !hold;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

FILE: sv/dpp_datapath.sv
module dpp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpp_pkg::ctl_t                       ctl,
	input  dpp_pkg::cfg_t                       cfg,
	input  logic [dpp_pkg::CODE_BITS-1:0]       in_first,
	input  logic [dpp_pkg::CODE_BITS-1:0]       in_second,
	input  logic                                in_valid,
	input  logic                                out_ready,
	output dpp_pkg::status_t                    st,
	output logic                                out_valid,
	output logic [dpp_pkg::OUT_DATA_W-1:0]      out_data,
	output logic [dpp_pkg::OUT_USER_W-1:0]      out_user
);
	import dpp_pkg::*;

	// latched codes
	logic [CODE_BITS-1:0] c1_q, c2_q;
	// divider state
	logic [CODE_BITS-1:0] span_q, rem_q;
	logic [TRAVEL_W-1:0]  quo_q;
	logic [ITER_W-1:0]    iter_q;
	logic                 zero_q, full_q;
	// travels and check results
	logic [TRAVEL_W-1:0]  t1_q, t2_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 mism_q, range_q;
	// output word
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic [CODE_BITS-1:0] code, lo, hi, clamped, span, offset;
	logic                 degen;
	logic [CODE_BITS:0]   rem2;
	logic                 qbit;
	logic [TRAVEL_W-1:0]  travel, gap;
	logic                 exceed;
	logic [COUNT_W-1:0]   count_next;
	logic                 mism_next, range_next;
	logic [TRAVEL_W:0]    tsum;

	// operand select and clamp
	always_comb begin
		code    = ctl.sel ? c2_q : c1_q;
		lo      = ctl.sel ? cfg.second_low : cfg.first_low;
		hi      = ctl.sel ? cfg.second_high : cfg.first_high;
		degen   = (hi <= lo);
		clamped = (code < lo) ? lo : ((code > hi) ? hi : code);
		span    = hi - lo;
		offset  = clamped - lo;
	end

	// one restoring division step
	always_comb begin
		rem2 = {rem_q, 1'b0};
		qbit = (rem2 >= {1'b0, span_q});
	end

	// travel with special cases, gap compare, range check
	always_comb begin
		if (zero_q) begin
			travel = '0;
		end else if (full_q) begin
			travel = '1;
		end else begin
			travel = quo_q;
		end
		gap    = (t1_q > t2_q) ? (t1_q - t2_q) : (t2_q - t1_q);
		exceed = (gap > cfg.gap_limit);
		if (!exceed) begin
			count_next = '0;
		end else if (count_q == '1) begin
			count_next = count_q;
		end else begin
			count_next = count_q + COUNT_W'(1);
		end
		mism_next  = exceed && (count_next > cfg.persist);
		range_next = (c1_q == '0) || (c2_q == '0) ||
			(c1_q >= cfg.over_range) || (c2_q >= cfg.over_range);
		tsum = {1'b0, t1_q} + {1'b0, t2_q};
	end

	// micro-op execution
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (ctl.go) begin
					c1_q <= in_first;
					c2_q <= in_second;
				end
			end
			OP_SETUP: begin
				span_q <= span;
				rem_q  <= offset;
				quo_q  <= '0;
				iter_q <= '0;
				zero_q <= degen;
				full_q <= !degen && (offset >= span);
			end
			OP_DIV: begin
				rem_q  <= qbit ? CODE_BITS'(rem2 - {1'b0, span_q}) : rem_q << 1;
				quo_q  <= {quo_q[TRAVEL_W-2:0], qbit};
				iter_q <= iter_q + ITER_W'(1);
			end
			OP_STORE: begin
				if (ctl.sel) begin
					t2_q <= travel;
				end else begin
					t1_q <= travel;
				end
			end
			OP_CHECK: begin
				mism_q  <= mism_next;
				range_q <= range_next;
			end
			default: begin
			end
		endcase
	end

	// gap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.op == OP_CHECK) begin
			count_q <= count_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && ctl.go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT && ctl.go) begin
			out_data_q <= OUT_DATA_W'({t2_q, t1_q, tsum[TRAVEL_W:1]});
			out_user_q <= {mism_q | range_q, range_q, mism_q};
		end
	end

	assign st.in_valid = in_valid;
	assign st.div_more = (iter_q != DIV_LAST);
	assign st.out_full = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign out_user    = out_user_q;

`ifndef NO_ASSERTIONS
	// a raised mismatch comes only from a nonzero gap counter
	a_mism_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_EMIT && ctl.go && mism_q) |-> (count_q != '0))
		else $error("mismatch flagged with empty gap counter");
	// a word is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(ctl.op == OP_EMIT && ctl.go))
		else $error("output word overwritten");
	// clamped offset never exceeds the span on a sound calibration
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_DIV && !zero_q && !full_q) |-> (rem_q < span_q))
		else $error("divider remainder out of bound");
`endif

endmodule
